/* rtl/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// same-cycle implication, checked out of reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

/* rtl/nfrc_pkg.sv */
package nfrc_pkg;

   localparam int HEADER_BYTES        = 7;
   localparam int CFG_KEEP            = 7;
   localparam int MAX_FRAME_BYTES_DEF = 262;
   localparam int RX_WINDOW_MS        = 1000;
   localparam int CFG_IDX_W           = $clog2(CFG_KEEP);

   // largest valid bandwidth index and spreading factor nibble
   localparam logic [3:0] BW_MAX      = 4'd3;
   localparam logic [3:0] SF_NIB_MAX  = 4'd6;
   localparam logic [3:0] SF_OFFSET   = 4'd6;

   localparam logic [15:0] OWN_DEV_ADDR_RST = 16'd0;
   localparam logic [7:0]  OWN_NET_ADDR_RST = 8'd0;
   localparam logic [15:0] NODE_ID_RST      = 16'd0;
   localparam logic [3:0]  CODE_ACK_RST     = 4'd1;
   localparam logic [3:0]  CODE_NACK_RST    = 4'd2;
   localparam logic [3:0]  CODE_CONFIG_RST  = 4'd3;
   localparam logic [7:0]  POWER_LIMIT_RST  = 8'd20;
   localparam logic [1:0]  REQ_BIT_RST      = 2'd0;

   typedef enum logic [2:0] {
      CSR_OWN_DEV_ADDR = 3'd0,
      CSR_OWN_NET_ADDR = 3'd1,
      CSR_NODE_ID      = 3'd2,
      CSR_CODE_ACK     = 3'd3,
      CSR_CODE_NACK    = 3'd4,
      CSR_CODE_CONFIG  = 3'd5,
      CSR_POWER_LIMIT  = 3'd6,
      CSR_REQ_BIT      = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      EV_IGNORED     = 3'd0,
      EV_OK          = 3'd1,
      EV_DATA_REQ    = 3'd2,
      EV_NACK        = 3'd3,
      EV_CONFIG_OK   = 3'd4,
      EV_ID_MISMATCH = 3'd5,
      EV_ERROR       = 3'd6
   } event_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       frame_end;
   } req_type;

   typedef struct packed {
      logic [2:0]  event_res;
      logic [7:0]  net_addr;
      logic [15:0] src_addr;
      logic [15:0] dest_addr;
      logic [15:0] new_sleep_time;
      logic [7:0]  new_power;
      logic [1:0]  new_bw;
      logic [3:0]  new_sf;
      logic [17:0] new_rx_window;
   } rsp_type;

   typedef struct packed {
      logic [15:0] own_dev_addr;
      logic [7:0]  own_net_addr;
      logic [15:0] node_id;
      logic [3:0]  code_ack;
      logic [3:0]  code_nack;
      logic [3:0]  code_config;
      logic [7:0]  power_limit;
      logic [1:0]  req_bit;
   } cfg_type;

   // one finished frame handed from capture to classification
   typedef struct packed {
      logic                     short_frame;
      logic [7:0]               net_addr;
      logic [15:0]              src_addr;
      logic [15:0]              dest_addr;
      logic [3:0]               ftype;
      logic [3:0]               flags;
      logic [CFG_KEEP-1:0][7:0] cfg;
   } frame_rec_type;

endpackage

/* rtl/nfrc_csr.sv */
module nfrc_csr (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [15:0]          csr_wdata,
   output nfrc_pkg::cfg_type    cfg
);

   nfrc_pkg::cfg_type cfg_ff;
   nfrc_pkg::cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (nfrc_pkg::csr_index_type'(csr_index))
            nfrc_pkg::CSR_OWN_DEV_ADDR: cfg_in.own_dev_addr = csr_wdata;
            nfrc_pkg::CSR_OWN_NET_ADDR: cfg_in.own_net_addr = csr_wdata[7:0];
            nfrc_pkg::CSR_NODE_ID:      cfg_in.node_id      = csr_wdata;
            nfrc_pkg::CSR_CODE_ACK:     cfg_in.code_ack     = csr_wdata[3:0];
            nfrc_pkg::CSR_CODE_NACK:    cfg_in.code_nack    = csr_wdata[3:0];
            nfrc_pkg::CSR_CODE_CONFIG:  cfg_in.code_config  = csr_wdata[3:0];
            nfrc_pkg::CSR_POWER_LIMIT:  cfg_in.power_limit  = csr_wdata[7:0];
            nfrc_pkg::CSR_REQ_BIT:      cfg_in.req_bit      = csr_wdata[1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_dev_addr <= nfrc_pkg::OWN_DEV_ADDR_RST;
         cfg_ff.own_net_addr <= nfrc_pkg::OWN_NET_ADDR_RST;
         cfg_ff.node_id      <= nfrc_pkg::NODE_ID_RST;
         cfg_ff.code_ack     <= nfrc_pkg::CODE_ACK_RST;
         cfg_ff.code_nack    <= nfrc_pkg::CODE_NACK_RST;
         cfg_ff.code_config  <= nfrc_pkg::CODE_CONFIG_RST;
         cfg_ff.power_limit  <= nfrc_pkg::POWER_LIMIT_RST;
         cfg_ff.req_bit      <= nfrc_pkg::REQ_BIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

/* rtl/nfrc_capture.sv */
`include "assert_macros.svh"

module nfrc_capture #(
   parameter int MAX_FRAME_BYTES = nfrc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  nfrc_pkg::req_type         req_payload,
   output logic                      rec_valid,
   output nfrc_pkg::frame_rec_type   rec,
   input  logic                      rec_take
);

   localparam int COUNT_W = $clog2(MAX_FRAME_BYTES + 1);
   localparam int HDR     = nfrc_pkg::HEADER_BYTES;
   localparam int KEEP    = nfrc_pkg::CFG_KEEP;
   localparam int IDX_W   = nfrc_pkg::CFG_IDX_W;

   logic [COUNT_W-1:0] count_ff, count_in;
   logic [7:0]         header_ff [HDR];
   logic [7:0]         header_upd [HDR];
   logic [7:0]         cfg_ff [KEEP];
   logic [7:0]         cfg_upd [KEEP];
   logic [7:0]         cfg_in [KEEP];
   logic               rec_valid_ff, rec_valid_in;
   nfrc_pkg::frame_rec_type rec_ff, rec_in;

   logic               byte_acc, last_acc;
   logic               below_max, cfg_we;
   logic [COUNT_W-1:0] pay_pos;
   logic [IDX_W-1:0]   pay_idx;

   assign req_stall = rec_valid_ff && !rec_take;
   assign byte_acc  = req_valid && !req_stall;
   assign last_acc  = byte_acc && req_payload.frame_end;
   assign rec_valid = rec_valid_ff;
   assign rec       = rec_ff;

   assign below_max = count_ff < COUNT_W'(MAX_FRAME_BYTES);
   assign pay_pos   = count_ff - COUNT_W'(HDR);
   assign pay_idx   = pay_pos[IDX_W-1:0];
   // payload byte kept only inside the first bytes and within the length byte
   assign cfg_we    = byte_acc && (count_ff >= COUNT_W'(HDR)) && below_max
                      && (pay_pos < COUNT_W'(KEEP))
                      && ({1'b0, pay_pos} < (COUNT_W + 1)'(header_ff[HDR-1]));

   always_comb begin
      for (int i = 0; i < HDR; i++) begin
         header_upd[i] = (byte_acc && count_ff == COUNT_W'(i)) ? req_payload.rx_byte
                                                              : header_ff[i];
      end
      for (int j = 0; j < KEEP; j++) begin
         cfg_upd[j] = (cfg_we && pay_idx == IDX_W'(j)) ? req_payload.rx_byte : cfg_ff[j];
         cfg_in[j]  = last_acc ? 8'd0 : cfg_upd[j];
      end
   end

   always_comb begin
      if (last_acc) begin
         count_in = '0;
      end else if (byte_acc && below_max) begin
         count_in = count_ff + COUNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rec_in.short_frame = count_ff < COUNT_W'(HDR - 1);
      rec_in.net_addr    = header_upd[0];
      rec_in.src_addr    = {header_upd[1], header_upd[2]};
      rec_in.dest_addr   = {header_upd[3], header_upd[4]};
      rec_in.ftype       = header_upd[5][7:4];
      rec_in.flags       = header_upd[5][3:0];
      for (int j = 0; j < KEEP; j++) begin
         rec_in.cfg[j] = cfg_upd[j];
      end
      if (last_acc) begin
         rec_valid_in = 1'b1;
      end else if (rec_take) begin
         rec_valid_in = 1'b0;
      end else begin
         rec_valid_in = rec_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rec_valid_ff <= 1'b0;
         for (int j = 0; j < KEEP; j++) begin
            cfg_ff[j] <= 8'd0;
         end
      end else begin
         count_ff     <= count_in;
         rec_valid_ff <= rec_valid_in;
         for (int j = 0; j < KEEP; j++) begin
            cfg_ff[j] <= cfg_in[j];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < HDR; i++) begin
         header_ff[i] <= header_upd[i];
      end
      if (last_acc) begin
         rec_ff <= rec_in;
      end
   end

   `ASSERT_IMPLIES(a_count_max, clock, reset, 1'b1, count_ff <= COUNT_W'(MAX_FRAME_BYTES))
   `ASSERT_NEXT(a_count_restart, clock, reset, last_acc, count_ff == '0)
   `ASSERT_NEXT(a_rec_loaded, clock, reset, last_acc, rec_valid_ff)

endmodule

/* rtl/nfrc_classify.sv */
`include "assert_macros.svh"

module nfrc_classify (
   input  logic                      clock,
   input  logic                      reset,
   input  nfrc_pkg::cfg_type         cfg,
   input  logic                      rec_valid,
   input  nfrc_pkg::frame_rec_type   rec,
   output logic                      rec_take,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output nfrc_pkg::rsp_type         rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   nfrc_pkg::rsp_type rsp_data_ff, rsp_data_in;
   nfrc_pkg::event_type ev;
   logic              mine, id_ok, req_flag;
   logic [3:0]        bw_nib, sf_nib;
   logic [7:0]        pw;
   logic              not_cfg_out, new_zero;

   assign rec_take  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign mine     = (rec.dest_addr == cfg.own_dev_addr) && (rec.net_addr == cfg.own_net_addr);
   assign id_ok    = {rec.cfg[0], rec.cfg[1]} == cfg.node_id;
   assign req_flag = rec.flags[cfg.req_bit];
   assign pw       = rec.cfg[4];
   assign bw_nib   = rec.cfg[5][7:4];
   assign sf_nib   = rec.cfg[5][3:0];

   always_comb begin
      priority if (mine) begin
         priority if (rec.ftype == cfg.code_ack) begin
            ev = req_flag ? nfrc_pkg::EV_DATA_REQ : nfrc_pkg::EV_OK;
         end else if (rec.ftype == cfg.code_nack) begin
            ev = nfrc_pkg::EV_NACK;
         end else if (rec.ftype == cfg.code_config) begin
            ev = id_ok ? nfrc_pkg::EV_CONFIG_OK : nfrc_pkg::EV_ID_MISMATCH;
         end else begin
            ev = nfrc_pkg::EV_OK;
         end
      end else if (rec.ftype == cfg.code_config) begin
         ev = id_ok ? nfrc_pkg::EV_CONFIG_OK : nfrc_pkg::EV_IGNORED;
      end else begin
         ev = nfrc_pkg::EV_ERROR;
      end
   end

   always_comb begin
      rsp_data_in = '0;
      if (!rec.short_frame) begin
         rsp_data_in.event_res = ev;
         rsp_data_in.net_addr  = rec.net_addr;
         rsp_data_in.src_addr  = rec.src_addr;
         rsp_data_in.dest_addr = rec.dest_addr;
         if (ev == nfrc_pkg::EV_CONFIG_OK) begin
            rsp_data_in.new_sleep_time = {rec.cfg[2], rec.cfg[3]};
            rsp_data_in.new_power      = (pw != 8'd0 && pw <= cfg.power_limit) ? pw : 8'd0;
            rsp_data_in.new_bw = (bw_nib != 4'd0 && bw_nib <= nfrc_pkg::BW_MAX)
                                 ? bw_nib[1:0] : 2'd0;
            rsp_data_in.new_sf = (sf_nib != 4'd0 && sf_nib <= nfrc_pkg::SF_NIB_MAX)
                                 ? sf_nib + nfrc_pkg::SF_OFFSET : 4'd0;
            rsp_data_in.new_rx_window = {10'd0, rec.cfg[6]} * 18'(nfrc_pkg::RX_WINDOW_MS);
         end
      end
      rsp_valid_in = rec_take ? rec_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rec_take && rec_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign not_cfg_out = rsp_valid_ff && (rsp_data_ff.event_res != nfrc_pkg::EV_CONFIG_OK);
   assign new_zero    = (rsp_data_ff.new_sleep_time == 16'd0) && (rsp_data_ff.new_power == 8'd0)
                        && (rsp_data_ff.new_rx_window == 18'd0);

   // settings only go out with an accepted config frame
   `ASSERT_IMPLIES(a_new_only_config, clock, reset, not_cfg_out, new_zero)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid_ff && rsp_stall, rsp_valid_ff)
   `ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid_ff && rsp_stall, $stable(rsp_data_ff))

endmodule

/* rtl/node_frame_receive_classifier_top.sv */
// channel  | ports                              | payload
// ---------+------------------------------------+------------------------------
// request  | req_valid, req_stall, req_payload  | rx_byte, frame_end
// response | rsp_valid, rsp_stall, rsp_data     | event_res, header, new settings
// csr      | csr_valid, csr_ready, csr_index,   | register index, write data
//          | csr_wdata                          |
//
// takes one byte per cycle unless req_stall is high; the edge that takes a frame's last byte
// loads its record, and the result register takes that record once it is free
// the byte capture registers and the result register are the two stages
// reset is synchronous and active high; it restores the register defaults and
// starts a new frame
// req_stall rises only while a finished frame waits and the result register is held
module node_frame_receive_classifier_top #(
   parameter int MAX_FRAME_BYTES = nfrc_pkg::MAX_FRAME_BYTES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  nfrc_pkg::req_type  req_payload,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output nfrc_pkg::rsp_type  rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_wdata
);

   nfrc_pkg::cfg_type       cfg;
   nfrc_pkg::frame_rec_type rec;
   logic                    rec_valid;
   logic                    rec_take;

   nfrc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   nfrc_capture #(
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_capture (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rec_valid   (rec_valid),
      .rec         (rec),
      .rec_take    (rec_take)
   );

   nfrc_classify u_classify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .rec_valid (rec_valid),
      .rec       (rec),
      .rec_take  (rec_take),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sim/tb.sv */
module tb;

   typedef enum {SET_RANDOM, SET_ONES, SET_ZEROS} setting_kind_type;
   typedef enum {FRAME_ANY, FRAME_SHORT, FRAME_LONG} frame_kind_type;

   // one row of the directed plan; ev/net/src/dst only count when typed is set
   typedef struct {
      logic [7:0]          rx;
      bit                  last;
      bit                  typed;
      nfrc_pkg::event_type ev;
      logic [7:0]          net;
      logic [15:0]         src;
      logic [15:0]         dst;
   } step_row_type;

   localparam int HDR = nfrc_pkg::HEADER_BYTES;
   localparam int KEEP = nfrc_pkg::CFG_KEEP;
   localparam int MAX_FRAME = nfrc_pkg::MAX_FRAME_BYTES_DEF;
   localparam int PHASE_ITEMS = 290;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   nfrc_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   nfrc_pkg::rsp_type rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [2:0]        csr_index = '0;
   logic [15:0]       csr_wdata = '0;

   // predictor state
   nfrc_pkg::cfg_type node_regs;
   int unsigned       rx_count;
   logic [7:0]        hdr [HDR];
   logic [7:0]        cfg_bytes [KEEP];

   nfrc_pkg::rsp_type pending_results [$];
   int          bad_results = 0;
   int          items_sent = 0;
   bit          no_gaps = 1'b0;
   bit          hold_rsp = 1'b0;

   always #5 clock = ~clock;

   node_frame_receive_classifier_top dut (
      .clock,
      .reset,
      .req_valid,
      .req_stall,
      .req_payload,
      .rsp_valid,
      .rsp_stall,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_wdata
   );

   function automatic bit classify_byte(input nfrc_pkg::req_type d,
                                        output nfrc_pkg::rsp_type r);
      int unsigned pos, total, p;
      logic [7:0]  net, pw;
      logic [15:0] dst, id;
      logic [3:0]  ftype, flags, bw, sf;
      bit          mine;
      nfrc_pkg::event_type ev;
      pos = rx_count;
      r = '0;
      if (pos < HDR) begin
         hdr[pos] = d.rx_byte;
      end else if (pos < MAX_FRAME) begin
         p = pos - HDR;
         // payload kept only within the length byte
         if (p < KEEP && p < hdr[HDR-1]) cfg_bytes[p] = d.rx_byte;
      end
      total = pos + 1;
      rx_count = (pos < MAX_FRAME) ? total : MAX_FRAME;
      if (!d.frame_end) return 1'b0;
      if (total >= HDR) begin
         net   = hdr[0];
         dst   = {hdr[3], hdr[4]};
         ftype = hdr[5][7:4];
         flags = hdr[5][3:0];
         id    = {cfg_bytes[0], cfg_bytes[1]};
         mine  = (dst == node_regs.own_dev_addr) && (net == node_regs.own_net_addr);
         if (mine) begin
            if (ftype == node_regs.code_ack)
               ev = flags[node_regs.req_bit] ? nfrc_pkg::EV_DATA_REQ : nfrc_pkg::EV_OK;
            else if (ftype == node_regs.code_nack)
               ev = nfrc_pkg::EV_NACK;
            else if (ftype == node_regs.code_config)
               ev = (id == node_regs.node_id) ? nfrc_pkg::EV_CONFIG_OK
                                              : nfrc_pkg::EV_ID_MISMATCH;
            else
               ev = nfrc_pkg::EV_OK;
         end else if (ftype == node_regs.code_config) begin
            ev = (id == node_regs.node_id) ? nfrc_pkg::EV_CONFIG_OK : nfrc_pkg::EV_IGNORED;
         end else begin
            ev = nfrc_pkg::EV_ERROR;
         end
         r.event_res = ev;
         r.net_addr  = net;
         r.src_addr  = {hdr[1], hdr[2]};
         r.dest_addr = dst;
         if (ev == nfrc_pkg::EV_CONFIG_OK) begin
            pw = cfg_bytes[4];
            bw = cfg_bytes[5][7:4];
            sf = cfg_bytes[5][3:0];
            r.new_sleep_time = {cfg_bytes[2], cfg_bytes[3]};
            r.new_power      = (pw != 0 && pw <= node_regs.power_limit) ? pw : 8'd0;
            r.new_bw         = (bw != 0 && bw <= nfrc_pkg::BW_MAX) ? bw[1:0] : 2'd0;
            r.new_sf         = (sf != 0 && sf <= nfrc_pkg::SF_NIB_MAX)
                               ? sf + nfrc_pkg::SF_OFFSET : 4'd0;
            r.new_rx_window  = 18'(cfg_bytes[6] * nfrc_pkg::RX_WINDOW_MS);
         end
      end
      rx_count = 0;
      foreach (cfg_bytes[i]) cfg_bytes[i] = '0;
      return 1'b1;
   endfunction

   // call at a rising edge; returns at the edge the item is taken
   task automatic send_item(input nfrc_pkg::req_type d, input bit typed,
                            input nfrc_pkg::rsp_type typed_rsp);
      int                gap;
      nfrc_pkg::rsp_type r;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= d;
      do @(posedge clock); while (req_stall);
      items_sent++;
      if (classify_byte(d, r)) pending_results.push_back(typed ? typed_rsp : r);
   endtask

   task automatic send_frame(input frame_kind_type kind);
      logic [7:0]  fb [$];
      logic [7:0]  pl [KEEP];
      logic [15:0] dst, id;
      logic [3:0]  ftype;
      int          plen;
      nfrc_pkg::req_type d;
      if (kind == FRAME_SHORT) begin
         repeat ($urandom_range(1, HDR - 1)) fb.push_back(8'($urandom));
      end else begin
         case ($urandom_range(0, 5))
            0: ftype = node_regs.code_ack;
            1: ftype = node_regs.code_nack;
            2, 3: ftype = node_regs.code_config;
            default: ftype = 4'($urandom);
         endcase
         dst = ($urandom_range(0, 3) != 0) ? node_regs.own_dev_addr : 16'($urandom);
         fb.push_back(($urandom_range(0, 3) != 0) ? node_regs.own_net_addr : 8'($urandom));
         fb.push_back(8'($urandom));
         fb.push_back(8'($urandom));
         fb.push_back(dst[15:8]);
         fb.push_back(dst[7:0]);
         fb.push_back({ftype, 4'($urandom)});
         case ($urandom_range(0, 3))
            0: fb.push_back(8'($urandom));
            1: fb.push_back(8'($urandom_range(0, KEEP - 1)));
            default: fb.push_back(8'(KEEP));
         endcase
         if (kind == FRAME_LONG)
            plen = $urandom_range(MAX_FRAME - HDR + 1, 290);
         else
            plen = $urandom_range(0, 1) ? KEEP : $urandom_range(0, 9);
         id = ($urandom_range(0, 3) != 0) ? node_regs.node_id : 16'($urandom);
         pl[0] = id[15:8];
         pl[1] = id[7:0];
         pl[2] = 8'($urandom);
         pl[3] = 8'($urandom);
         pl[4] = $urandom_range(0, 1) ? 8'($urandom_range(0, int'(node_regs.power_limit) + 1))
                                      : 8'($urandom);
         pl[5] = ($urandom_range(0, 3) != 0)
                 ? {4'($urandom_range(0, 4)), 4'($urandom_range(0, 7))} : 8'($urandom);
         pl[6] = 8'($urandom);
         for (int i = 0; i < plen; i++) fb.push_back(i < KEEP ? pl[i] : 8'($urandom));
      end
      foreach (fb[i]) begin
         d.rx_byte   = fb[i];
         d.frame_end = (i == fb.size() - 1);
         send_item(d, 1'b0, '0);
      end
   endtask

   // register writes go back to back, valid drops after the last one
   task automatic program_node(input setting_kind_type kind);
      nfrc_pkg::csr_index_type idx;
      logic [15:0]             mask, val;
      for (int i = 0; i < 8; i++) begin
         idx = nfrc_pkg::csr_index_type'(i);
         case (idx)
            nfrc_pkg::CSR_OWN_DEV_ADDR, nfrc_pkg::CSR_NODE_ID: mask = 16'hFFFF;
            nfrc_pkg::CSR_OWN_NET_ADDR, nfrc_pkg::CSR_POWER_LIMIT: mask = 16'h00FF;
            nfrc_pkg::CSR_REQ_BIT: mask = 16'h0003;
            default: mask = 16'h000F;
         endcase
         case (kind)
            SET_ONES: val = mask;
            SET_ZEROS: val = '0;
            default: val = 16'($urandom) & mask;
         endcase
         csr_valid <= 1'b1;
         csr_index <= idx;
         csr_wdata <= val;
         do @(posedge clock); while (!csr_ready);
         case (idx)
            nfrc_pkg::CSR_OWN_DEV_ADDR: node_regs.own_dev_addr = val;
            nfrc_pkg::CSR_OWN_NET_ADDR: node_regs.own_net_addr = val[7:0];
            nfrc_pkg::CSR_NODE_ID:      node_regs.node_id      = val;
            nfrc_pkg::CSR_CODE_ACK:     node_regs.code_ack     = val[3:0];
            nfrc_pkg::CSR_CODE_NACK:    node_regs.code_nack    = val[3:0];
            nfrc_pkg::CSR_CODE_CONFIG:  node_regs.code_config  = val[3:0];
            nfrc_pkg::CSR_POWER_LIMIT:  node_regs.power_limit  = val[7:0];
            nfrc_pkg::CSR_REQ_BIT:      node_regs.req_bit      = val[1:0];
         endcase
      end
      csr_valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      step_row_type      plan [22];
      setting_kind_type  kinds [5];
      nfrc_pkg::rsp_type r;
      nfrc_pkg::req_type d;
      int                base;
      plan = '{
         // short frame
         '{8'hFF, 1, 1, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         // ack with every flag set, request bit 0
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'hFF, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'hFF, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h1F, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 1, 1, nfrc_pkg::EV_DATA_REQ, 8'h00, 16'hFFFF, 16'h0000},
         // config frame for this node with a full payload
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h12, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h34, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h3A, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h07, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h00, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h01, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'hF4, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h14, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'h36, 0, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000},
         '{8'hFF, 1, 0, nfrc_pkg::EV_IGNORED,  8'h00, 16'h0000, 16'h0000}
      };
      kinds = '{SET_RANDOM, SET_ONES, SET_ZEROS, SET_RANDOM, SET_RANDOM};

      node_regs.own_dev_addr = nfrc_pkg::OWN_DEV_ADDR_RST;
      node_regs.own_net_addr = nfrc_pkg::OWN_NET_ADDR_RST;
      node_regs.node_id      = nfrc_pkg::NODE_ID_RST;
      node_regs.code_ack     = nfrc_pkg::CODE_ACK_RST;
      node_regs.code_nack    = nfrc_pkg::CODE_NACK_RST;
      node_regs.code_config  = nfrc_pkg::CODE_CONFIG_RST;
      node_regs.power_limit  = nfrc_pkg::POWER_LIMIT_RST;
      node_regs.req_bit      = nfrc_pkg::REQ_BIT_RST;
      rx_count = 0;
      foreach (hdr[i]) hdr[i] = '0;
      foreach (cfg_bytes[i]) cfg_bytes[i] = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         d.rx_byte   = plan[i].rx;
         d.frame_end = plan[i].last;
         r = '0;
         r.event_res = plan[i].ev;
         r.net_addr  = plan[i].net;
         r.src_addr  = plan[i].src;
         r.dest_addr = plan[i].dst;
         send_item(d, plan[i].typed, r);
      end

      for (int phase = 0; phase < 5; phase++) begin
         wait_idle();
         program_node(kinds[phase]);
         base = items_sent;
         if (phase == 3) begin
            // hold the result side while short frames pile up behind it
            no_gaps  = 1'b1;
            hold_rsp = 1'b1;
            repeat (12) send_frame(FRAME_SHORT);
         end
         if (phase == 2 || phase == 4) send_frame(FRAME_LONG);
         while (items_sent - base < PHASE_ITEMS) begin
            no_gaps = ($urandom_range(0, 5) == 0);
            send_frame($urandom_range(0, 11) == 0 ? FRAME_SHORT : FRAME_ANY);
         end
         no_gaps = 1'b0;
      end

      wait_idle();
      if (bad_results == 0 && pending_results.size() == 0)
         $display("node_frame_receive_classifier_top regression: pass");
      else
         $display("node_frame_receive_classifier_top regression: fail");
      $finish;
   end

   initial begin : result_side
      int                n;
      nfrc_pkg::rsp_type want;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            n = 80;
         end else begin
            n = no_gaps ? 0 : $urandom_range(0, 3);
         end
         if (n > 0) begin
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         if (pending_results.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("unexpected result ev=%0d at %0t", rsp_data.event_res, $time);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.event_res !== want.event_res
                || rsp_data.net_addr !== want.net_addr
                || rsp_data.src_addr !== want.src_addr
                || rsp_data.dest_addr !== want.dest_addr
                || rsp_data.new_sleep_time !== want.new_sleep_time
                || rsp_data.new_power !== want.new_power
                || rsp_data.new_bw !== want.new_bw
                || rsp_data.new_sf !== want.new_sf
                || rsp_data.new_rx_window !== want.new_rx_window) begin
               bad_results++;
               if (bad_results <= 10) begin
                  $display("mismatch at %0t exp: ev=%0d net=%h src=%h dst=%h",
                           $time, want.event_res, want.net_addr, want.src_addr,
                           want.dest_addr);
                  $display("   exp: sleep=%h pwr=%h bw=%0d sf=%0d win=%0d",
                           want.new_sleep_time, want.new_power, want.new_bw,
                           want.new_sf, want.new_rx_window);
                  $display("   act: ev=%0d net=%h src=%h dst=%h",
                           rsp_data.event_res, rsp_data.net_addr, rsp_data.src_addr,
                           rsp_data.dest_addr);
                  $display("   act: sleep=%h pwr=%h bw=%0d sf=%0d win=%0d",
                           rsp_data.new_sleep_time, rsp_data.new_power, rsp_data.new_bw,
                           rsp_data.new_sf, rsp_data.new_rx_window);
               end
            end
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("node_frame_receive_classifier_top regression: fail");
      $finish;
   end

endmodule
